@@ hdl/macd_ema_indicator_defines.svh @@
// ----------------------------------------------------------------------------
// MACD indicator assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef MACD_EMA_INDICATOR_DEFINES_SVH
`define MACD_EMA_INDICATOR_DEFINES_SVH

// same-cycle implication
`define MACD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("macd: implication failed");

// next-cycle implication
`define MACD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("macd: next-cycle implication failed");

`endif

@@ hdl/macd_pkg.sv @@
// ----------------------------------------------------------------------------
// MACD indicator package
// Widths, register reset values, register indexes and controller commands.
// ----------------------------------------------------------------------------
package macd_pkg;

    localparam int PRICE_BITS  = 32;
    localparam int WFRAC_BITS  = 16;
    localparam int WEIGHT_BITS = WFRAC_BITS + 1;
    localparam int MACD_BITS   = PRICE_BITS + 1;
    localparam int HIST_BITS   = PRICE_BITS + 2;
    localparam int DIFF_BITS   = PRICE_BITS + 2;
    localparam int PROD_BITS   = WEIGHT_BITS + 1 + DIFF_BITS;
    localparam int START_BITS  = 10;
    localparam int COUNT_BITS  = 11;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << WFRAC_BITS;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

    localparam logic [WEIGHT_BITS-1:0] FAST_WEIGHT_RST   = WEIGHT_BITS'(10082);
    localparam logic [WEIGHT_BITS-1:0] SLOW_WEIGHT_RST   = WEIGHT_BITS'(4855);
    localparam logic [WEIGHT_BITS-1:0] SIGNAL_WEIGHT_RST = WEIGHT_BITS'(13107);
    localparam logic [START_BITS-1:0]  SIGNAL_START_RST  = START_BITS'(26);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FAST_WEIGHT   = 2'd0,
        CFG_SLOW_WEIGHT   = 2'd1,
        CFG_SIGNAL_WEIGHT = 2'd2,
        CFG_SIGNAL_START  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_FAST,
        MUL_SLOW,
        MUL_SIGNAL
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     upd_fast;
        logic     upd_slow;
        logic     upd_signal;
        logic     out_load;
    } t_dp_cmd;

endpackage

@@ hdl/macd_ctrl.sv @@
// ----------------------------------------------------------------------------
// MACD controller
// Sequences the shared multiplier over fast, slow and signal averages.
// ----------------------------------------------------------------------------
module macd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output macd_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_FAST,
        S_MUL_SLOW,
        S_ADD_SLOW,
        S_MUL_SIG,
        S_ADD_SIG,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    macd_pkg::t_dp_cmd cmd;

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = macd_pkg::MUL_FAST;
        n_state     = r_state;
        unique case (r_state)
            S_IDLE: begin
                cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MUL_FAST;
                end
            end
            S_MUL_FAST: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = macd_pkg::MUL_FAST;
                n_state     = S_MUL_SLOW;
            end
            S_MUL_SLOW: begin
                cmd.upd_fast = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = macd_pkg::MUL_SLOW;
                n_state      = S_ADD_SLOW;
            end
            S_ADD_SLOW: begin
                cmd.upd_slow = 1'b1;
                n_state      = S_MUL_SIG;
            end
            S_MUL_SIG: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = macd_pkg::MUL_SIGNAL;
                n_state     = S_ADD_SIG;
            end
            S_ADD_SIG: begin
                cmd.upd_signal = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

@@ hdl/macd_dp.sv @@
// ----------------------------------------------------------------------------
// MACD datapath
// Configuration registers, averages, shared multiplier and result register.
// ----------------------------------------------------------------------------
module macd_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  macd_pkg::t_dp_cmd                      i_cmd,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [macd_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [macd_pkg::WEIGHT_BITS-1:0]       i_cfg_data,
    input  logic [macd_pkg::PRICE_BITS-1:0]        i_price,
    input  logic                                   i_first_of_series,
    output logic signed [macd_pkg::MACD_BITS-1:0]  o_macd_value,
    output logic signed [macd_pkg::MACD_BITS-1:0]  o_signal_value,
    output logic signed [macd_pkg::HIST_BITS-1:0]  o_histogram_value
);

    logic [macd_pkg::WEIGHT_BITS-1:0]     r_fast_w, r_slow_w, r_sig_w;
    logic [macd_pkg::START_BITS-1:0]      r_sig_start;
    logic [macd_pkg::PRICE_BITS-1:0]      r_price, r_fast, r_slow;
    logic                                 r_first;
    logic signed [macd_pkg::MACD_BITS-1:0] r_sig;
    logic [macd_pkg::COUNT_BITS-1:0]      r_count;
    logic signed [macd_pkg::PROD_BITS-1:0] r_prod;
    logic signed [macd_pkg::MACD_BITS-1:0] r_macd_o, r_sig_o;
    logic signed [macd_pkg::HIST_BITS-1:0] r_hist_o;

    logic [macd_pkg::WEIGHT_BITS-1:0]      w_sel;
    logic signed [macd_pkg::WEIGHT_BITS:0] w_s;
    logic signed [macd_pkg::DIFF_BITS-1:0] diff;
    logic signed [macd_pkg::DIFF_BITS-1:0] step;
    logic signed [macd_pkg::MACD_BITS-1:0] macd;
    logic [macd_pkg::COUNT_BITS-1:0]       start_ext;
    logic                                  sig_seed, sig_on;
    logic [macd_pkg::DIFF_BITS-1:0]        n_fast, n_slow;
    logic signed [macd_pkg::DIFF_BITS-1:0] n_sig;

    function automatic logic [macd_pkg::WEIGHT_BITS-1:0] clamp_w(
        input logic [macd_pkg::WEIGHT_BITS-1:0] w
    );
        return (w > macd_pkg::WEIGHT_ONE) ? macd_pkg::WEIGHT_ONE : w;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign start_ext   = macd_pkg::COUNT_BITS'(r_sig_start);
    assign sig_seed    = (r_count == start_ext);
    assign sig_on      = (r_count >= start_ext);
    assign macd        = $signed({1'b0, r_fast}) - $signed({1'b0, r_slow});
    assign step        = macd_pkg::DIFF_BITS'(r_prod >>> macd_pkg::WFRAC_BITS);
    assign n_fast      = {2'b00, r_fast} + step;
    assign n_slow      = {2'b00, r_slow} + step;
    assign n_sig       = macd_pkg::DIFF_BITS'(r_sig) + step;

    always_comb begin
        case (i_cmd.mul_sel)
            macd_pkg::MUL_FAST: begin
                w_sel = r_first ? macd_pkg::WEIGHT_ONE : clamp_w(r_fast_w);
                diff  = $signed({2'b00, r_price}) - $signed({2'b00, r_fast});
            end
            macd_pkg::MUL_SLOW: begin
                w_sel = r_first ? macd_pkg::WEIGHT_ONE : clamp_w(r_slow_w);
                diff  = $signed({2'b00, r_price}) - $signed({2'b00, r_slow});
            end
            default: begin
                w_sel = sig_seed ? macd_pkg::WEIGHT_ONE : clamp_w(r_sig_w);
                diff  = macd_pkg::DIFF_BITS'(macd) - macd_pkg::DIFF_BITS'(r_sig);
            end
        endcase
        w_s = $signed({1'b0, w_sel});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_w    <= macd_pkg::FAST_WEIGHT_RST;
            r_slow_w    <= macd_pkg::SLOW_WEIGHT_RST;
            r_sig_w     <= macd_pkg::SIGNAL_WEIGHT_RST;
            r_sig_start <= macd_pkg::SIGNAL_START_RST;
            r_fast      <= '0;
            r_slow      <= '0;
            r_sig       <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (macd_pkg::t_cfg_idx'(i_cfg_index))
                    macd_pkg::CFG_FAST_WEIGHT:   r_fast_w    <= i_cfg_data;
                    macd_pkg::CFG_SLOW_WEIGHT:   r_slow_w    <= i_cfg_data;
                    macd_pkg::CFG_SIGNAL_WEIGHT: r_sig_w     <= i_cfg_data;
                    macd_pkg::CFG_SIGNAL_START:
                        r_sig_start <= i_cfg_data[macd_pkg::START_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (i_first_of_series) begin
                    r_count <= '0;
                end else if (r_count != macd_pkg::COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.upd_fast) begin
                r_fast <= n_fast[macd_pkg::PRICE_BITS-1:0];
            end
            if (i_cmd.upd_slow) begin
                r_slow <= n_slow[macd_pkg::PRICE_BITS-1:0];
            end
            if (i_cmd.upd_signal && sig_on) begin
                r_sig <= n_sig[macd_pkg::MACD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_price <= i_price;
            r_first <= i_first_of_series;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_s * diff;
        end
        if (i_cmd.out_load) begin
            r_macd_o <= macd;
            r_sig_o  <= sig_on ? r_sig : '0;
            r_hist_o <= sig_on ? (macd_pkg::HIST_BITS'(macd) - macd_pkg::HIST_BITS'(r_sig))
                               : '0;
        end
    end

    assign o_macd_value      = r_macd_o;
    assign o_signal_value    = r_sig_o;
    assign o_histogram_value = r_hist_o;

endmodule

@@ hdl/macd_ema_indicator.sv @@
// ----------------------------------------------------------------------------
// MACD EMA indicator
// Fast and slow exponential averages of a price stream, their difference,
// and a signal line with histogram.
// ----------------------------------------------------------------------------
// One price is taken at a time. On its way from acceptance to a result in
// the output register, the single 18x34 multiplier, registered at its output,
// is used in turn for the fast, slow and signal averages, each product
// followed by an add cycle that updates its average, with the fast add
// overlapping the slow multiply. The next price is accepted in the cycle after
// the result is loaded, even if that result still waits to be taken, so no new
// price enters before the previous one has reached the output register. A
// request that finishes while the previous result still waits holds in its
// last state until that result is taken. Configuration writes are always ready.
module macd_ema_indicator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [macd_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [macd_pkg::WEIGHT_BITS-1:0]       i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [macd_pkg::PRICE_BITS-1:0]        i_price,
    input  logic                                   i_first_of_series,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [macd_pkg::MACD_BITS-1:0]  o_macd_value,
    output logic signed [macd_pkg::MACD_BITS-1:0]  o_signal_value,
    output logic signed [macd_pkg::HIST_BITS-1:0]  o_histogram_value
);

    macd_pkg::t_dp_cmd cmd;

    macd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    macd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_price           (i_price),
        .i_first_of_series (i_first_of_series),
        .o_macd_value      (o_macd_value),
        .o_signal_value    (o_signal_value),
        .o_histogram_value (o_histogram_value)
    );

endmodule

@@ hdl/macd_ema_indicator_chk.sv @@
// ----------------------------------------------------------------------------
// MACD EMA indicator port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "macd_ema_indicator_defines.svh"

module macd_ema_indicator_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic signed [macd_pkg::MACD_BITS-1:0]  o_macd_value,
    input logic signed [macd_pkg::MACD_BITS-1:0]  o_signal_value,
    input logic signed [macd_pkg::HIST_BITS-1:0]  o_histogram_value
);

    logic signed [macd_pkg::HIST_BITS-1:0] hist_exp;
    logic                                  in_acc, out_stall;

    assign hist_exp  = macd_pkg::HIST_BITS'(o_macd_value)
                     - macd_pkg::HIST_BITS'(o_signal_value);
    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    `MACD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
        o_out_valid && $stable(o_macd_value) && $stable(o_signal_value) && $stable(o_histogram_value))

    `MACD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_in_ready)

    `MACD_ASSERT_IMPL(a_hist_form, i_clk, i_rst_n, o_out_valid,
        (o_histogram_value == hist_exp) || (o_histogram_value == '0))

endmodule

bind macd_ema_indicator macd_ema_indicator_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_macd_value      (o_macd_value),
    .o_signal_value    (o_signal_value),
    .o_histogram_value (o_histogram_value)
);
